FILE: design/cffsa_pkg.sv
// ----------------------------------------------------------------------------
// cffsa_pkg: shared types and constants of the circular slot allocator
// Item formats, status and operation codes, and the bitmap geometry.
// ----------------------------------------------------------------------------
package cffsa_pkg;

  localparam int MAX_SLOTS = 256;
  localparam int SLOT_W    = 8;
  localparam int SIZE_W    = 9;
  localparam int WORD_W    = 32;
  localparam int BIT_W     = $clog2(WORD_W);
  localparam int NWORDS    = MAX_SLOTS / WORD_W;
  localparam int WIDX_W    = SLOT_W - BIT_W;
  localparam int STATUS_W  = 3;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(256);
  localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(MAX_SLOTS);

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_GRANTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FREED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_INVALID = 3'd4;

  typedef struct packed {
    logic              op;
    logic [SLOT_W-1:0] slot;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   granted_slot;
  } out_item_t;

  typedef struct packed {
    logic             hit;
    logic [BIT_W-1:0] idx;
    logic             last_visit;
  } scan_t;

endpackage

FILE: design/cffsa_scan.sv
// ----------------------------------------------------------------------------
// cffsa_scan: free-bit search within one bitmap word
// Masks one occupancy word to the part of the ring this visit covers and
// picks the lowest free slot in it.
// ----------------------------------------------------------------------------
module cffsa_scan import cffsa_pkg::*; (
  input  logic [WORD_W-1:0] word_i,
  input  logic [WIDX_W-1:0] cur_word_i,
  input  logic [WIDX_W-1:0] start_word_i,
  input  logic [BIT_W-1:0]  start_bit_i,
  input  logic              first_i,
  input  logic [SIZE_W-1:0] size_i,
  output scan_t             scan_o
);

  logic [SIZE_W-1:0] lim;
  logic [WORD_W-1:0] cand;
  logic              last_visit;

  // slots left in the ring from the base of this word
  assign lim        = size_i - {1'b0, cur_word_i, {BIT_W{1'b0}}};
  assign last_visit = !first_i && (cur_word_i == start_word_i);

  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      cand[b] = !word_i[b] && (SIZE_W'(b) < lim);
      if (first_i && (BIT_W'(b) < start_bit_i)) begin
        cand[b] = 1'b0;
      end
      if (last_visit && (BIT_W'(b) >= start_bit_i)) begin
        cand[b] = 1'b0;
      end
    end
  end

  // lowest set candidate wins
  always_comb begin
    scan_o            = '0;
    scan_o.hit        = |cand;
    scan_o.last_visit = last_visit;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (cand[b]) begin
        scan_o.idx = BIT_W'(b);
      end
    end
  end

endmodule

FILE: design/circular_first_free_slot_allocator.sv
// ----------------------------------------------------------------------------
// circular_first_free_slot_allocator: ring slot allocator on a bitmap memory
// An allocate may scan up to 8 extra words past the first, one word read a cycle;
// no new item is accepted until the previous one has finished.
// Reset clears per-word valid flops at once (no sweep); size resets to 256.
// ----------------------------------------------------------------------------
module circular_first_free_slot_allocator import cffsa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration: ring size
  input  logic              cfg_we_i,
  input  logic [SIZE_W-1:0] cfg_wdata_i,
  // request channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_item_t          in_item_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_item_t         out_item_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RD   = 3'b010,
    S_EVAL = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [SIZE_W-1:0] size_q;
  logic [SIZE_W-1:0] eff_size;
  logic [WIDX_W-1:0] last_word;

  // captured request
  logic              op_q;
  logic [SLOT_W-1:0] slot_q;
  logic [WIDX_W-1:0] start_word;
  logic [BIT_W-1:0]  start_bit;
  logic              invalid;

  // scan position
  logic [WIDX_W-1:0] cur_q, next_word;
  logic              first_q, first_d;

  // bitmap memory and per-word valid flops
  logic [WORD_W-1:0] mem_q [NWORDS];
  logic [NWORDS-1:0] row_vld_q;
  logic [WORD_W-1:0] rd_data_q;
  logic              rd_vld_q;
  logic              rd_en;
  logic [WIDX_W-1:0] rd_addr;
  logic              mem_we;
  logic [WORD_W-1:0] wdata;
  logic [WORD_W-1:0] word;

  // result register
  logic              out_valid_q;
  out_item_t         out_item_q, res;
  logic              out_free;
  logic              done;
  logic              load;
  logic              accept;
  logic              rel_bit;
  scan_t             scan;

  // Size register: a zero size acts as one slot, anything above capacity
  // acts as full capacity.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SIZE_RESET;
    end else if (cfg_we_i) begin
      size_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (size_q == '0) begin
      eff_size = SIZE_W'(1);
    end else if (size_q > SIZE_MAX) begin
      eff_size = SIZE_MAX;
    end else begin
      eff_size = size_q;
    end
  end

  // word holding the last slot of the ring
  logic [SIZE_W-1:0] size_m1;
  assign size_m1   = eff_size - SIZE_W'(1);
  assign last_word = size_m1[SLOT_W-1:BIT_W];

  assign start_word = slot_q[SLOT_W-1:BIT_W];
  assign start_bit  = slot_q[BIT_W-1:0];
  assign invalid    = ({1'b0, slot_q} >= eff_size);
  assign next_word  = (cur_q == last_word) ? '0 : cur_q + WIDX_W'(1);

  // Accept only with no item in flight; a finished result may still wait
  // in the output register.
  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= in_item_i.op;
      slot_q <= in_item_i.slot;
    end
  end

  // A word never written reads as all free.
  assign word = rd_vld_q ? rd_data_q : '0;

  cffsa_scan u_scan (
    .word_i       (word),
    .cur_word_i   (cur_q),
    .start_word_i (start_word),
    .start_bit_i  (start_bit),
    .first_i      (first_q),
    .size_i       (eff_size),
    .scan_o       (scan)
  );

  assign rel_bit = word[start_bit];

  // Decide the item: invalid slots and releases finish on the first word;
  // an allocate finishes on a hit or after the wrap back to its start word.
  always_comb begin
    res   = '0;
    wdata = word;
    done  = 1'b1;
    if (invalid) begin
      res.status = ST_INVALID;
    end else if (op_q == OP_RELEASE) begin
      res.status = rel_bit ? ST_FREED : ST_EMPTY;
      wdata      = word & ~(WORD_W'(1) << start_bit);
    end else if (scan.hit) begin
      res.status       = ST_GRANTED;
      res.granted_slot = {cur_q, scan.idx};
      wdata            = word | (WORD_W'(1) << scan.idx);
    end else if (scan.last_visit) begin
      res.status = ST_FULL;
    end else begin
      done = 1'b0;
    end
  end

  // Hold the decision while the output register holds a stalled result.
  assign load   = (state_q == S_EVAL) && done && out_free;
  assign mem_we = load && !invalid &&
                  (((op_q == OP_RELEASE) && rel_bit) || ((op_q == OP_ALLOC) && scan.hit));

  always_comb begin
    state_d = state_q;
    rd_en   = 1'b0;
    rd_addr = next_word;
    first_d = first_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_RD;
        end
      end
      S_RD: begin
        // fetch the word holding the requested slot
        rd_en   = 1'b1;
        rd_addr = start_word;
        first_d = 1'b1;
        state_d = S_EVAL;
      end
      S_EVAL: begin
        if (done) begin
          if (out_free) begin
            state_d = S_IDLE;
          end
        end else begin
          // advance around the ring, one word a cycle
          rd_en   = 1'b1;
          first_d = 1'b0;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      first_q <= 1'b0;
      cur_q   <= '0;
    end else begin
      state_q <= state_d;
      first_q <= first_d;
      if (rd_en) begin
        cur_q <= rd_addr;
      end
    end
  end

  // Bitmap memory: one write port at the current word, one registered read.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[cur_q] <= wdata;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (mem_we) begin
        row_vld_q[cur_q] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_q <= row_vld_q[rd_addr];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef SYNTHESIS
  a_grant_in_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.status == ST_GRANTED) |->
      ({1'b0, out_item_o.granted_slot} < eff_size))
    else $error("granted slot outside the ring");

  a_no_grant_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.status != ST_GRANTED) |-> (out_item_o.granted_slot == '0))
    else $error("slot reported without a grant");

  a_accept_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_RD))
    else $error("accepted item did not start a read");

  a_scan_in_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EVAL) && !invalid |-> (cur_q <= last_word))
    else $error("scan left the ring");

  a_write_on_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == S_EVAL) && out_free)
    else $error("bitmap written outside a finishing decision");
`endif

endmodule
